[sv/smacc_pkg.sv]
// Shared constants, command codes and pipeline types for the sign-magnitude ALU.
package smacc_pkg;

    localparam int WordW  = 24;
    localparam int MagW   = 23;
    localparam int HalfW  = 12;
    localparam int CmdW   = 5;
    localparam int CntW   = 3;
    localparam int DivdW  = 2 * MagW;
    localparam int ProdW  = 2 * MagW;

    localparam int DivStepsDefault = 4;

    localparam logic [CmdW-1:0] CMD_LOAD    = 5'd0;
    localparam logic [CmdW-1:0] CMD_ADD     = 5'd1;
    localparam logic [CmdW-1:0] CMD_SUB     = 5'd2;
    localparam logic [CmdW-1:0] CMD_SADD    = 5'd3;
    localparam logic [CmdW-1:0] CMD_SSUB    = 5'd4;
    localparam logic [CmdW-1:0] CMD_MUL     = 5'd5;
    localparam logic [CmdW-1:0] CMD_SMUL    = 5'd6;
    localparam logic [CmdW-1:0] CMD_DIV     = 5'd7;
    localparam logic [CmdW-1:0] CMD_LIMIT   = 5'd8;
    localparam logic [CmdW-1:0] CMD_OR      = 5'd9;
    localparam logic [CmdW-1:0] CMD_AND     = 5'd10;
    localparam logic [CmdW-1:0] CMD_NEGMAG  = 5'd11;
    localparam logic [CmdW-1:0] CMD_COMPL   = 5'd12;
    localparam logic [CmdW-1:0] CMD_SPLSL   = 5'd13;
    localparam logic [CmdW-1:0] CMD_WHLSL   = 5'd14;
    localparam logic [CmdW-1:0] CMD_HISL    = 5'd15;
    localparam logic [CmdW-1:0] CMD_ROTL    = 5'd16;
    localparam logic [CmdW-1:0] CMD_SPLSR   = 5'd17;
    localparam logic [CmdW-1:0] CMD_WHLSR   = 5'd18;
    localparam logic [CmdW-1:0] CMD_HISR    = 5'd19;
    localparam logic [CmdW-1:0] CMD_ROTR    = 5'd20;

    typedef struct packed {
        logic             valid;
        logic [CmdW-1:0]  cmd;
        logic             mode;
        logic [WordW-1:0] acc;
        logic [WordW-1:0] low;
        logic             div_zero;
        logic             div_ovf;
        logic             q_neg;
        logic             r_neg;
    } t_item;

endpackage

[sv/smacc_front.sv]
// Front stage: decode, the simple operations computed here, multiplier and divider operand setup.
module smacc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic                         i_mode,
    input  logic [smacc_pkg::CmdW-1:0]   i_command,
    input  logic [smacc_pkg::WordW-1:0]  i_acc_in,
    input  logic [smacc_pkg::WordW-1:0]  i_low_in,
    input  logic [smacc_pkg::WordW-1:0]  i_operand,
    input  logic [smacc_pkg::CntW-1:0]   i_shift_amount,
    output smacc_pkg::t_item             o_item,
    output logic [smacc_pkg::MagW-1:0]   o_mul_a,
    output logic [smacc_pkg::MagW-1:0]   o_mul_b,
    output logic                         o_mul_neg,
    output logic [smacc_pkg::DivdW-1:0]  o_dividend,
    output logic [smacc_pkg::MagW-1:0]   o_divisor
);
    import smacc_pkg::*;

    function automatic logic [WordW-1:0] sm_word(input logic signed [WordW:0] v);
        logic [WordW:0] m;
        begin
            m = v[WordW] ? -v : v;
            if (m > {2'b00, {MagW{1'b1}}}) begin
                m = {2'b00, {MagW{1'b1}}};
            end
            sm_word = (v[WordW] && m != '0) ? {1'b1, m[MagW-1:0]} : {1'b0, m[MagW-1:0]};
        end
    endfunction

    function automatic logic [HalfW-1:0] limit_half(input logic [HalfW-1:0] a,
                                                    input logic [HalfW-1:0] o);
        logic signed [HalfW+1:0] x;
        logic signed [HalfW+1:0] y;
        logic signed [HalfW+1:0] ny;
        begin
            x  = {{2{a[HalfW-1]}}, a};
            y  = {{2{o[HalfW-1]}}, o};
            ny = -y;
            if (x > y) begin
                x = y;
            end
            if (x < ny) begin
                x = ny;
            end
            limit_half = x[HalfW-1:0];
        end
    endfunction

    t_item              r_item;
    logic [MagW-1:0]    r_mul_a, r_mul_b;
    logic               r_mul_neg;
    logic [DivdW-1:0]   r_dividend;
    logic [MagW-1:0]    r_divisor;

    t_item              n_item;
    logic [MagW-1:0]    n_mul_a, n_mul_b;
    logic               n_mul_neg;

    logic [HalfW-1:0]   ah, al, oh, ol;
    logic [3:0]         sh;
    logic signed [WordW:0] va, vo;
    logic [HalfW-1:0]   ah_l, al_l, ah_r, al_r;
    logic [2*WordW-1:0] dbl_l, dbl_r;
    logic               sgn_x;

    always_comb begin
        ah    = i_acc_in[WordW-1:HalfW];
        al    = i_acc_in[HalfW-1:0];
        oh    = i_operand[WordW-1:HalfW];
        ol    = i_operand[HalfW-1:0];
        sh    = (i_shift_amount == '0) ? 4'd8 : {1'b0, i_shift_amount};
        va    = i_acc_in[WordW-1] ? -{2'b00, i_acc_in[MagW-1:0]} : {2'b00, i_acc_in[MagW-1:0]};
        vo    = i_operand[WordW-1] ? -{2'b00, i_operand[MagW-1:0]}
                                   : {2'b00, i_operand[MagW-1:0]};
        ah_l  = ah << sh;
        al_l  = al << sh;
        ah_r  = ah >> sh;
        al_r  = al >> sh;
        dbl_l = {i_acc_in, i_acc_in} << sh;
        dbl_r = {i_acc_in, i_acc_in} >> sh;
        sgn_x = i_acc_in[WordW-1] ^ i_operand[WordW-1];

        n_item          = '0;
        n_item.valid    = i_take;
        n_item.cmd      = i_command;
        n_item.mode     = i_mode;
        n_item.acc      = i_acc_in;
        n_item.low      = i_low_in;
        n_item.div_zero = (i_operand[MagW-1:0] == '0);
        n_item.div_ovf  = (i_acc_in[MagW-1:0] >= i_operand[MagW-1:0]);
        n_item.q_neg    = sgn_x;
        n_item.r_neg    = i_acc_in[WordW-1];

        n_mul_a   = i_acc_in[MagW-1:0];
        n_mul_b   = i_operand[MagW-1:0];
        n_mul_neg = sgn_x;

        case (i_command)
            CMD_LOAD:   n_item.acc = i_operand;
            CMD_ADD:    n_item.acc = sm_word(va + vo);
            CMD_SUB:    n_item.acc = sm_word(va - vo);
            CMD_SADD:   n_item.acc = {ah + oh, al + ol};
            CMD_SSUB:   n_item.acc = {ah - oh, al - ol};
            CMD_SMUL: begin
                n_mul_a = {{(MagW-9){1'b0}}, i_acc_in[MagW-1:14]};
                n_mul_b = {{(MagW-9){1'b0}}, i_operand[MagW-1:14]};
            end
            CMD_DIV:    n_mul_neg = 1'b0;
            CMD_LIMIT:  n_item.acc = {limit_half(ah, oh), limit_half(al, ol)};
            CMD_OR:     n_item.acc = i_mode ? (i_acc_in | i_low_in) : i_acc_in;
            CMD_AND:    n_item.acc = i_acc_in & i_low_in;
            CMD_NEGMAG: n_item.acc = {1'b1, i_acc_in[MagW-1:0]};
            CMD_COMPL:  n_item.acc = {~i_acc_in[WordW-1], i_acc_in[MagW-1:0]};
            CMD_SPLSL:  n_item.acc = {ah_l, al_l};
            CMD_WHLSL:  n_item.acc = dbl_l[WordW-1:0];
            CMD_HISL:   n_item.acc = {ah_l, al};
            CMD_ROTL:   n_item.acc = i_mode ? dbl_l[2*WordW-1:WordW] : {ah, al_l};
            CMD_SPLSR:  n_item.acc = {ah_r, al_r};
            CMD_WHLSR:  n_item.acc = i_acc_in >> sh;
            CMD_HISR:   n_item.acc = {ah_r, al};
            CMD_ROTR:   n_item.acc = i_mode ? dbl_r[WordW-1:0] : {ah, al_r};
            default:    n_item.acc = i_acc_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_a    <= n_mul_a;
        r_mul_b    <= n_mul_b;
        r_mul_neg  <= n_mul_neg;
        r_dividend <= {i_acc_in[MagW-1:0], i_low_in[MagW-1:0]};
        r_divisor  <= i_operand[MagW-1:0];
    end

    assign o_item     = r_item;
    assign o_mul_a    = r_mul_a;
    assign o_mul_b    = r_mul_b;
    assign o_mul_neg  = r_mul_neg;
    assign o_dividend = r_dividend;
    assign o_divisor  = r_divisor;

endmodule

[sv/smacc_mul.sv]
// Registered 23x23 multiplier with a delay line to match the divider depth.
module smacc_mul #(
    parameter int Lat = 12
) (
    input  logic                         i_clk,
    input  logic [smacc_pkg::MagW-1:0]   i_a,
    input  logic [smacc_pkg::MagW-1:0]   i_b,
    input  logic                         i_neg,
    output logic [smacc_pkg::ProdW-1:0]  o_prod,
    output logic                         o_neg
);
    import smacc_pkg::*;

    logic [ProdW-1:0] r_prod [Lat];
    logic             r_neg  [Lat];

    always_ff @(posedge i_clk) begin
        r_prod[0] <= i_a * i_b;
        r_neg[0]  <= i_neg;
        for (int i = 1; i < Lat; i++) begin
            r_prod[i] <= r_prod[i-1];
            r_neg[i]  <= r_neg[i-1];
        end
    end

    assign o_prod = r_prod[Lat-1];
    assign o_neg  = r_neg[Lat-1];

endmodule

[sv/smacc_div.sv]
// Pipelined restoring divider: 46-bit dividend by 23-bit divisor, Steps quotient bits per stage.
module smacc_div #(
    parameter int Steps  = 4,
    parameter int Stages = 12
) (
    input  logic                         i_clk,
    input  logic [smacc_pkg::DivdW-1:0]  i_dividend,
    input  logic [smacc_pkg::MagW-1:0]   i_divisor,
    output logic [smacc_pkg::MagW-1:0]   o_quo,
    output logic [smacc_pkg::MagW-1:0]   o_rem
);
    import smacc_pkg::*;

    logic [MagW-1:0]  r_rem [Stages];
    logic [MagW-1:0]  r_quo [Stages];
    logic [DivdW-1:0] r_dvd [Stages];
    logic [MagW-1:0]  r_dvs [Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [MagW-1:0]  p_rem, p_quo, p_dvs;
        logic [DivdW-1:0] p_dvd;
        logic [MagW-1:0]  n_rem, n_quo, dvs;
        logic [DivdW-1:0] n_dvd;
        logic [MagW:0]    t;

        // First stage starts from the raw operands, later ones from the stage before.
        if (s == 0) begin : g_head
            assign p_rem = '0;
            assign p_quo = '0;
            assign p_dvd = i_dividend;
            assign p_dvs = i_divisor;
        end else begin : g_body
            assign p_rem = r_rem[s-1];
            assign p_quo = r_quo[s-1];
            assign p_dvd = r_dvd[s-1];
            assign p_dvs = r_dvs[s-1];
        end

        always_comb begin
            n_rem = p_rem;
            n_quo = p_quo;
            n_dvd = p_dvd;
            dvs   = p_dvs;
            t = '0;
            for (int j = 0; j < Steps; j++) begin
                if (s * Steps + j < DivdW) begin
                    t     = {n_rem, n_dvd[DivdW-1]};
                    n_dvd = n_dvd << 1;
                    if (t >= {1'b0, dvs}) begin
                        t     = t - {1'b0, dvs};
                        n_quo = {n_quo[MagW-2:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[MagW-2:0], 1'b0};
                    end
                    n_rem = t[MagW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
            r_dvd[s] <= n_dvd;
            r_dvs[s] <= dvs;
        end
    end

    assign o_quo = r_quo[Stages-1];
    assign o_rem = r_rem[Stages-1];

endmodule

[sv/sign_magnitude_accumulator_alu.sv]
// Top level of the pipelined sign-magnitude accumulator ALU.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+---------------------
//  request  | i_command i_acc_in i_low_in i_operand i_shift_amount | i_start, o_busy
//  result   | o_acc_out o_low_out o_error                        | o_done strobe
//  config   | i_cfg_data (mode_extended)                         | i_cfg_valid, o_cfg_ready
//
// A request is taken on every cycle that i_start is high; o_busy stays low.
// The pipeline holds one front stage, Stages = ceil(46 / DivSteps) divider stages (the
// multiplier result is delayed to match) and one output stage.
// The divide sets the depth; every command walks the same pipeline so results keep order.
// Reset clears the valid bits and sets mode_extended to 1. The receiver cannot stall.
module sign_magnitude_accumulator_alu #(
    parameter int DivSteps = smacc_pkg::DivStepsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [smacc_pkg::CmdW-1:0]   i_command,
    input  logic [smacc_pkg::WordW-1:0]  i_acc_in,
    input  logic [smacc_pkg::WordW-1:0]  i_low_in,
    input  logic [smacc_pkg::WordW-1:0]  i_operand,
    input  logic [smacc_pkg::CntW-1:0]   i_shift_amount,
    output logic                         o_done,
    output logic [smacc_pkg::WordW-1:0]  o_acc_out,
    output logic [smacc_pkg::WordW-1:0]  o_low_out,
    output logic                         o_error,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);
    import smacc_pkg::*;

    localparam int Stages = (DivdW + DivSteps - 1) / DivSteps;

    logic             r_mode;
    t_item            front_item;
    logic [MagW-1:0]  mul_a, mul_b, divisor, quo, rem;
    logic             mul_neg_in, mul_neg;
    logic [DivdW-1:0] dividend;
    logic [ProdW-1:0] prod;

    t_item            r_pipe [Stages];
    logic             r_done, r_err;
    logic [WordW-1:0] r_acc, r_low;

    t_item            tail;
    logic [WordW-1:0] n_acc, n_low;
    logic             n_err;

    // Never hold off a request: the pipeline takes one every cycle.
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    smacc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (i_start),
        .i_mode         (r_mode),
        .i_command      (i_command),
        .i_acc_in       (i_acc_in),
        .i_low_in       (i_low_in),
        .i_operand      (i_operand),
        .i_shift_amount (i_shift_amount),
        .o_item         (front_item),
        .o_mul_a        (mul_a),
        .o_mul_b        (mul_b),
        .o_mul_neg      (mul_neg_in),
        .o_dividend     (dividend),
        .o_divisor      (divisor)
    );

    smacc_mul #(.Lat(Stages)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_neg  (mul_neg_in),
        .o_prod (prod),
        .o_neg  (mul_neg)
    );

    smacc_div #(.Steps(DivSteps), .Stages(Stages)) u_div (
        .i_clk      (i_clk),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    // Advance the item alongside the divider so the merge sees aligned data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) begin
                r_pipe[i].valid <= 1'b0;
            end
        end else begin
            r_pipe[0] <= front_item;
            for (int i = 1; i < Stages; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign tail = r_pipe[Stages-1];

    // Merge: pick the multiplier, the divider or the front result.
    always_comb begin
        n_acc = tail.acc;
        n_low = tail.low;
        n_err = 1'b0;
        if (tail.cmd == CMD_MUL || tail.cmd == CMD_SMUL ||
            (tail.cmd == CMD_DIV && !tail.mode)) begin
            n_acc = {mul_neg && prod != '0, prod[ProdW-1:MagW]};
            n_low = {1'b0, prod[MagW-1:0]};
        end else if (tail.cmd == CMD_DIV) begin
            if (tail.div_zero) begin
                n_err = 1'b1;
            end else if (tail.div_ovf) begin
                // Saturate the quotient; the remainder is still exact.
                n_err = 1'b1;
                n_acc = {tail.q_neg, {MagW{1'b1}}};
                n_low = {tail.r_neg && rem != '0, rem};
            end else begin
                n_acc = {tail.q_neg && quo != '0, quo};
                n_low = {tail.r_neg && rem != '0, rem};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_low <= n_low;
        r_err <= n_err;
    end

    assign o_done    = r_done;
    assign o_acc_out = r_acc;
    assign o_low_out = r_low;
    assign o_error   = r_err;

endmodule

[test/testbench.sv]
// Self-checking testbench for the sign-magnitude accumulator ALU.
module testbench;
    import smacc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 20;
    localparam int MagMax        = 'h7FFFFF;

    typedef struct packed {
        logic [WordW-1:0] acc;
        logic [WordW-1:0] low;
        logic             err;
    } t_alu_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic [CmdW-1:0]  i_command;
    logic [WordW-1:0] i_acc_in;
    logic [WordW-1:0] i_low_in;
    logic [WordW-1:0] i_operand;
    logic [CntW-1:0]  i_shift_amount;
    logic             o_done;
    logic [WordW-1:0] o_acc_out;
    logic [WordW-1:0] o_low_out;
    logic             o_error;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_data;

    t_alu_result pending_results[$];
    logic        mode_ext;
    int          mismatch_count;
    int          quiet_cycles;
    int          burst_left;

    sign_magnitude_accumulator_alu dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- prediction ----------------

    function automatic int sm_val(logic [WordW-1:0] w);
        int m;
        m = int'(w[MagW-1:0]);
        return w[WordW-1] ? -m : m;
    endfunction

    function automatic logic [WordW-1:0] sm_sat(int v);
        if (v > MagMax) v = MagMax;
        if (v < -MagMax) v = -MagMax;
        if (v < 0) return {1'b1, 23'(-v)};
        return 24'(v);
    endfunction

    function automatic int sext_half(logic [HalfW-1:0] h);
        return h[HalfW-1] ? int'(h) - 4096 : int'(h);
    endfunction

    function automatic logic [HalfW-1:0] clamp_half(logic [HalfW-1:0] a, logic [HalfW-1:0] o);
        int x;
        int y;
        x = sext_half(a);
        y = sext_half(o);
        if (x > y) x = y;
        if (x < -y) x = -y;
        return 12'(x);
    endfunction

    // Product of two magnitudes: high 23 bits to acc (with sign), low 23 bits to low.
    function automatic t_alu_result mag_product(longint unsigned ma, longint unsigned mb,
                                                logic neg);
        t_alu_result r;
        longint unsigned p;
        p = ma * mb;
        r.acc = {1'b0, 23'(p >> 23)};
        r.low = {1'b0, 23'(p)};
        r.err = 1'b0;
        if (neg && p != 0) r.acc[WordW-1] = 1'b1;
        return r;
    endfunction

    function automatic t_alu_result predict_alu(logic [CmdW-1:0] cmd, logic [WordW-1:0] a,
                                                logic [WordW-1:0] l, logic [WordW-1:0] op,
                                                logic [CntW-1:0] cnt, logic mode);
        t_alu_result r;
        int n;
        logic [HalfW-1:0] ah, al, oh, ol, hx, lx;
        logic neg;
        longint unsigned d, dvd, q, rem;
        logic [2*WordW-1:0] rot;
        r.acc = a;
        r.low = l;
        r.err = 1'b0;
        n = (cnt == 0) ? 8 : int'(cnt);
        ah = a[23:12];
        al = a[11:0];
        oh = op[23:12];
        ol = op[11:0];
        neg = a[WordW-1] ^ op[WordW-1];
        case (cmd)
            CMD_LOAD:  r.acc = op;
            CMD_ADD:   r.acc = sm_sat(sm_val(a) + sm_val(op));
            CMD_SUB:   r.acc = sm_sat(sm_val(a) - sm_val(op));
            CMD_SADD:  r.acc = {12'(ah + oh), 12'(al + ol)};
            CMD_SSUB:  r.acc = {12'(ah - oh), 12'(al - ol)};
            CMD_MUL:   r = mag_product(a[MagW-1:0], op[MagW-1:0], neg);
            CMD_SMUL:  r = mag_product(a[22:14], op[22:14], neg);
            CMD_DIV: begin
                if (!mode) begin
                    r = mag_product(a[MagW-1:0], op[MagW-1:0], 1'b0);
                end else if (op[MagW-1:0] == 0) begin
                    r.err = 1'b1;
                end else begin
                    d   = op[MagW-1:0];
                    dvd = {a[MagW-1:0], l[MagW-1:0]};
                    q   = dvd / d;
                    rem = dvd % d;
                    if (q > 64'h7FFFFF) begin
                        r.err = 1'b1;
                        q = 64'h7FFFFF;
                    end
                    r.acc = {neg && q != 0, 23'(q)};
                    r.low = {a[WordW-1] && rem != 0, 23'(rem)};
                end
            end
            CMD_LIMIT: r.acc = {clamp_half(ah, oh), clamp_half(al, ol)};
            CMD_OR:    if (mode) r.acc = a | l;
            CMD_AND:   r.acc = a & l;
            CMD_NEGMAG: r.acc[WordW-1] = 1'b1;
            CMD_COMPL: r.acc[WordW-1] = ~a[WordW-1];
            CMD_SPLSL: begin
                hx = ah << n;
                lx = al << n;
                r.acc = {hx, lx};
            end
            CMD_WHLSL: r.acc = a << n;
            CMD_HISL: begin
                hx = ah << n;
                r.acc = {hx, al};
            end
            CMD_ROTL: begin
                if (mode) begin
                    rot = {a, a} << n;
                    r.acc = rot[2*WordW-1:WordW];
                end else begin
                    lx = al << n;
                    r.acc = {ah, lx};
                end
            end
            CMD_SPLSR: r.acc = {ah >> n, al >> n};
            CMD_WHLSR: r.acc = a >> n;
            CMD_HISR:  r.acc = {ah >> n, al};
            CMD_ROTR: begin
                if (mode) begin
                    rot = {a, a} >> n;
                    r.acc = rot[WordW-1:0];
                end else begin
                    r.acc = {ah, al >> n};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: acc %h low %h err %b",
                         $time, o_acc_out, o_low_out, o_error);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_acc_out !== want.acc) begin
                    $display("%0t: acc expected %h actual %h", $time, want.acc, o_acc_out);
                    mismatch_count++;
                end
                if (o_low_out !== want.low) begin
                    $display("%0t: low expected %h actual %h", $time, want.low, o_low_out);
                    mismatch_count++;
                end
                if (o_error !== want.err) begin
                    $display("%0t: error expected %b actual %b", $time, want.err, o_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Count cycles with work outstanding but no handshake at all.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (pending_results.size() != 0 || i_start || i_cfg_valid) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("sign_magnitude_accumulator_alu verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    // Present one request and hold it until accepted.
    task automatic send_request(logic [CmdW-1:0] cmd, logic [WordW-1:0] a,
                                logic [WordW-1:0] l, logic [WordW-1:0] op,
                                logic [CntW-1:0] cnt);
        @(negedge i_clk);
        i_start        = 1'b1;
        i_command      = cmd;
        i_acc_in       = a;
        i_low_in       = l;
        i_operand      = op;
        i_shift_amount = cnt;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        pending_results.push_back(predict_alu(cmd, a, l, op, cnt, mode_ext));
    endtask

    task automatic idle_cycles(int k);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (k - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Write mode_extended, only with the pipeline empty.
    task automatic write_mode(logic v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        mode_ext = v;
    endtask

    function automatic logic [WordW-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'hFFFFFF;
            4: return {$urandom_range(0, 1) == 1, 23'($urandom_range(0, 15))};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_every_command();
        for (int c = 0; c <= int'(CMD_ROTR); c++)
            send_request(5'(c), 24'hFFFFFF, 24'h7FFFFF, 24'h800001, 3'd0);
        send_request(CMD_ADD, 24'h7FFFFF, 24'h0, 24'h000001, 3'd1);   // positive saturation
        send_request(CMD_SUB, 24'hFFFFFF, 24'h0, 24'h000005, 3'd1);   // negative saturation
        send_request(CMD_ADD, 24'h800005, 24'h0, 24'h000005, 3'd1);   // zero comes out positive
        send_request(CMD_MUL, 24'h800000, 24'h0, 24'h123456, 3'd1);   // zero product stays positive
        send_request(CMD_SADD, 24'hFFFFFF, 24'h0, 24'h001001, 3'd1);  // halves wrap apart
        send_request(CMD_SSUB, 24'h000000, 24'h0, 24'h001001, 3'd1);
        send_request(CMD_SMUL, 24'hFFFFFF, 24'h0, 24'h7FFFFF, 3'd1);
    endtask

    task automatic test_divide_cases();
        send_request(CMD_DIV, 24'h812345, 24'h654321, 24'h800000, 3'd0); // zero divisor
        send_request(CMD_DIV, 24'h400000, 24'h000000, 24'h000003, 3'd0); // quotient overflow
        send_request(CMD_DIV, 24'h800001, 24'h000007, 24'h000003, 3'd0); // negative dividend
        send_request(CMD_DIV, 24'h000001, 24'h000000, 24'h800002, 3'd0); // negative divisor
        send_request(CMD_DIV, 24'h800000, 24'h000006, 24'h800003, 3'd0); // exact, signs clear
        send_request(CMD_DIV, 24'h7FFFFE, 24'h7FFFFF, 24'h7FFFFF, 3'd0);
    endtask

    task automatic test_limit_cases();
        send_request(CMD_LIMIT, 24'h7FF7FF, 24'h0, 24'h100100, 3'd0); // clamp from above
        send_request(CMD_LIMIT, 24'h801801, 24'h0, 24'h100100, 3'd0); // clamp from below
        send_request(CMD_LIMIT, 24'h123456, 24'h0, 24'h800800, 3'd0); // most negative limit
        send_request(CMD_LIMIT, 24'h005FFB, 24'h0, 24'hFFEFFE, 3'd0); // negative limits
    endtask

    task automatic test_shift_counts();
        for (int k = 0; k < 8; k++)
            for (int c = int'(CMD_SPLSL); c <= int'(CMD_ROTR); c++)
                send_request(5'(c), 24'hA5C3E1, 24'h0, 24'h0, 3'(k));
    endtask

    task automatic test_unused_commands();
        for (int c = int'(CMD_ROTR) + 1; c < 32; c++)
            send_request(5'(c), 24'($urandom), 24'($urandom), 24'($urandom), 3'($urandom));
    endtask

    task automatic test_mode_clear();
        write_mode(1'b0);
        send_request(CMD_DIV, 24'hFFFFFF, 24'h123456, 24'h7FFFFF, 3'd0); // magnitude multiply
        send_request(CMD_OR, 24'h0F0F0F, 24'hF0F0F0, 24'h0, 3'd0);       // OR does nothing
        for (int k = 0; k < 8; k++) begin
            send_request(CMD_ROTL, 24'hFEDCBA, 24'h0, 24'h0, 3'(k));
            send_request(CMD_ROTR, 24'hFEDCBA, 24'h0, 24'h0, 3'(k));
        end
        write_mode(1'b1);
    endtask

    // Random requests in bursts; divides mostly kept in range so quotients are real.
    task automatic test_random_mix(int count);
        logic [CmdW-1:0] cmd;
        logic [WordW-1:0] a, l, op;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            end
            burst_left--;
            cmd = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 20));
            a  = pick_word();
            l  = pick_word();
            op = pick_word();
            if (cmd == CMD_DIV && $urandom_range(0, 3) != 0 && op[MagW-1:0] > 1)
                a[MagW-1:0] = 23'($urandom_range(0, int'(op[MagW-1:0]) - 1));
            send_request(cmd, a, l, op, 3'($urandom));
            if (i == count / 2) wait_drained();   // hold off until the pipe is empty
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_command      = '0;
        i_acc_in       = '0;
        i_low_in       = '0;
        i_operand      = '0;
        i_shift_amount = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        mode_ext       = 1'b1;
        mismatch_count = 0;
        quiet_cycles   = 0;
        burst_left     = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_every_command();
        test_divide_cases();
        test_limit_cases();
        test_unused_commands();
        test_shift_counts();
        test_mode_clear();
        test_random_mix(500);
        write_mode(1'b0);
        test_random_mix(500);
        write_mode(1'b1);
        test_random_mix(500);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("sign_magnitude_accumulator_alu verification clean");
        end else begin
            $display("sign_magnitude_accumulator_alu verification failed");
        end
        $finish;
    end

endmodule
